// ===== rtl/rfidp_pkg.sv =====
// Shared constants and helpers for the inventory frame parser.
// No dependencies.
package rfidp_pkg;

  localparam int unsigned PosW  = 17;
  localparam int unsigned CapW  = 7;

  // Frame markers and header codes
  localparam logic [7:0] StartMark  = 8'hAA;
  localparam logic [7:0] EndMark    = 8'hDD;
  localparam logic [15:0] ErrReply  = 16'h01FF;  // type 01, command FF
  localparam logic [15:0] NotifyInv = 16'h0222;  // type 02, command 22

  localparam logic [CapW-1:0] CapReset = 7'd65;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StShort    = 3'd1;
  localparam logic [2:0] StMarker   = 3'd2;
  localparam logic [2:0] StLength   = 3'd3;
  localparam logic [2:0] StChecksum = 3'd4;
  localparam logic [2:0] StErrReply = 3'd5;
  localparam logic [2:0] StNotify   = 3'd6;
  localparam logic [2:0] StIdLen    = 3'd7;

  // Register index on the config port
  localparam logic RegIdCap = 1'b0;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < 4'd10) begin
      r = 7'h30 + {3'b000, nib};
    end else begin
      r = 7'h37 + {3'b000, nib};
    end
    return r;
  endfunction

endpackage

// ===== rtl/rfid_inventory_frame_parser_unit.sv =====
// Top level of the reader reply frame parser.
// Depends on rfidp_pkg and rfidp_ram.
//
// Usage
//   Slave stream: one frame byte per item in s_axis_tdata_i, s_axis_tlast_i
//   high on the final byte (the DD marker). Frame layout:
//   AA, type, command, length hi, length lo, payload[length], sum, DD.
//   Master stream: one result per item. A failing frame gives one status item;
//   a good inventory notify gives one item per tag identifier byte, as two
//   uppercase ASCII hex characters with its index. tlast marks the final item
//   of the frame.
//   APB: one register, id_char_capacity at byte address 0 (reset 65).
// Input and output flow
//   Bytes without the end flag are taken one per cycle while the FSM is idle,
//   even while a result is still waiting on the master side. The end byte is
//   checked in the cycle it is accepted; a failing verdict moves to the status
//   state, which loads the status item once the output register is free. A good
//   frame reads the identifier RAM once per result, per byte a read issue, then
//   a load of the output register. tready is low during that burst.
// Reset and stalls
//   Reset clears the frame state and the FSM; the identifier RAM is not
//   cleared, a good frame only reads entries it wrote itself. A stalled
//   receiver simply holds the output register; the burst pauses with it.
module rfid_inventory_frame_parser_unit #(
  parameter int unsigned MAX_ID_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // frame bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // frame_end
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] status, [9:3] hex_high,
                                        // [16:10] hex_low, [21:17] byte_index,
                                        // [23:22] zero
  output logic        m_axis_tlast_o,   // last
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  import rfidp_pkg::*;

  localparam int unsigned AW = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_ID_BYTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATUS,
    S_READ,
    S_LOAD
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [CapW-1:0] cap_q;
  logic            cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_wr && paddr_i[2] == RegIdCap) begin
      cap_q <= pwdata_i[CapW-1:0];
    end
  end

  assign prdata_o = (paddr_i[2] == RegIdCap) ? {{(32-CapW){1'b0}}, cap_q} : 32'd0;

  // ---------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------
  state_e          state_q;
  logic            in_acc;
  logic            byte_acc;   // byte without end flag
  logic            end_acc;    // final byte of a frame
  logic [PosW-1:0] pos_q;
  logic [7:0]      sum_q;
  logic [7:0]      sum_prev_q;
  logic [7:0]      prev_q;
  logic            start_ok_q;
  logic [15:0]     tc_q;
  logic [15:0]     len_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign byte_acc = in_acc & ~s_axis_tlast_i;
  assign end_acc  = in_acc & s_axis_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      sum_prev_q <= '0;
      prev_q     <= '0;
      start_ok_q <= 1'b0;
      tc_q       <= '0;
      len_q      <= '0;
    end else if (end_acc) begin
      // every outcome starts the next frame afresh
      pos_q      <= '0;
      sum_q      <= '0;
      sum_prev_q <= '0;
      prev_q     <= '0;
      start_ok_q <= 1'b0;
      tc_q       <= '0;
      len_q      <= '0;
    end else if (byte_acc) begin
      if (pos_q == 17'd0) begin
        start_ok_q <= (s_axis_tdata_i == StartMark);
      end
      if (pos_q == 17'd1) tc_q[15:8]  <= s_axis_tdata_i;
      if (pos_q == 17'd2) tc_q[7:0]   <= s_axis_tdata_i;
      if (pos_q == 17'd3) len_q[15:8] <= s_axis_tdata_i;
      if (pos_q == 17'd4) len_q[7:0]  <= s_axis_tdata_i;
      if (pos_q != 17'd0) begin
        sum_prev_q <= sum_q;
        sum_q      <= sum_q + s_axis_tdata_i;
      end
      prev_q <= s_axis_tdata_i;
      if (pos_q != '1) begin
        pos_q <= pos_q + 17'd1;  // saturates, so an overlong frame fails length
      end
    end
  end

  // ---------------------------------------------------------------------
  // Identifier store: frame bytes 8 onwards
  // ---------------------------------------------------------------------
  logic [PosW-1:0] id_off;
  logic            id_we;
  logic            rd_en;
  logic [CW-1:0]   idx_q;
  logic [7:0]      rd_data;

  assign id_off = pos_q - 17'd8;
  assign id_we  = byte_acc && (pos_q >= 17'd8) &&
                  (id_off < PosW'(MAX_ID_BYTES));
  assign rd_en  = (state_q == S_READ);

  rfidp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ID_BYTES),
    .ADDR_W(AW)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (id_we),
    .waddr_i(id_off[AW-1:0]),
    .wdata_i(s_axis_tdata_i),
    .re_i   (rd_en),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  // ---------------------------------------------------------------------
  // End-of-frame checks, in priority order
  // ---------------------------------------------------------------------
  logic [15:0]     n_id;
  logic [PosW-1:0] len_ext;
  logic [2:0]      verdict;

  assign n_id    = len_q - 16'd5;
  assign len_ext = {1'b0, len_q} + 17'd6;   // last byte sits at position len+6

  always_comb begin
    priority if (pos_q < 17'd6 || cap_q == '0) begin
      verdict = StShort;
    end else if (!start_ok_q || s_axis_tdata_i != EndMark) begin
      verdict = StMarker;
    end else if (pos_q != len_ext) begin
      verdict = StLength;
    end else if (sum_prev_q != prev_q) begin
      verdict = StChecksum;
    end else if (tc_q == ErrReply) begin
      verdict = StErrReply;
    end else if (tc_q != NotifyInv || len_q < 16'd5) begin
      verdict = StNotify;
    end else if (n_id == 16'd0 || n_id > 16'(MAX_ID_BYTES) ||
                 {n_id, 1'b1} > {10'd0, cap_q}) begin
      verdict = StIdLen;
    end else begin
      verdict = StOk;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  logic [2:0]    stat_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] idx_nxt;
  logic          out_free;
  logic          out_load;   // output register takes a new item this cycle
  logic          out_vld_q;
  logic [2:0]    o_stat_q;
  logic [6:0]    o_hi_q;
  logic [6:0]    o_lo_q;
  logic [4:0]    o_idx_q;
  logic          o_last_q;
  logic [CW+4:0] idx_wide;

  assign out_free = ~out_vld_q | m_axis_tready_i;
  assign out_load = out_free & ((state_q == S_STATUS) | (state_q == S_LOAD));
  assign idx_nxt  = idx_q + 1'b1;
  assign idx_wide = {5'd0, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stat_q    <= StOk;
      n_q       <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      o_stat_q  <= StOk;
      o_hi_q    <= '0;
      o_lo_q    <= '0;
      o_idx_q   <= '0;
      o_last_q  <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready_i && !out_load) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (end_acc) begin
            stat_q <= verdict;
            n_q    <= n_id[CW-1:0];
            idx_q  <= '0;
            state_q <= (verdict == StOk) ? S_READ : S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            o_stat_q  <= stat_q;
            o_hi_q    <= '0;
            o_lo_q    <= '0;
            o_idx_q   <= '0;
            o_last_q  <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // RAM data holds until the next read, so waiting here is safe
          if (out_free) begin
            out_vld_q <= 1'b1;
            o_stat_q  <= StOk;
            o_hi_q    <= hex_char(rd_data[7:4]);
            o_lo_q    <= hex_char(rd_data[3:0]);
            o_idx_q   <= idx_wide[4:0];
            o_last_q  <= (idx_nxt == n_q);
            idx_q     <= idx_nxt;
            state_q   <= (idx_nxt == n_q) ? S_IDLE : S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, o_idx_q, o_lo_q, o_hi_q, o_stat_q};
  assign m_axis_tlast_o  = o_last_q;

endmodule

// ===== rtl/rfidp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module rfidp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
